// ===== rtl/core/pts_pkg.sv =====
package pts_pkg;

   // default sizes of the thread ring and the semaphore set
   localparam int PTS_THREADS    = 6;
   localparam int PTS_SEMAPHORES = 4;

   // fixed field widths
   localparam int OP_W      = 3;
   localparam int SEM_IDX_W = 2;
   localparam int THREAD_W  = 3;
   localparam int TICKS_W   = 32;
   localparam int COUNT_W   = 32;
   localparam int BLK_W     = 3;
   localparam int PRIO_W    = 8;
   localparam int PRIOS_W   = 48;

   localparam logic [PRIOS_W-1:0] PRIO_RESET = 48'h0505_0505_0505;
   localparam logic [PRIO_W-1:0]  PRIO_NONE  = 8'd255;

   typedef enum logic [OP_W-1:0] {
      OP_TICK    = 3'd0,
      OP_RESCHED = 3'd1,
      OP_SLEEP   = 3'd2,
      OP_WAIT    = 3'd3,
      OP_SIGNAL  = 3'd4,
      OP_INIT    = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEM,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MODE_TICK,
      MODE_RESCHED,
      MODE_SIGNAL
   } mode_type;

endpackage

// ===== rtl/core/pts_if.sv =====
interface pts_req_if import pts_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      operation;
   logic [SEM_IDX_W-1:0] sem_index;
   logic [TICKS_W-1:0]   sleep_ticks;
   logic signed [COUNT_W-1:0] init_count;

   modport source (output valid, operation, sem_index, sleep_ticks, init_count,
                   input ready);
   modport sink   (input valid, operation, sem_index, sleep_ticks, init_count,
                   output ready);
endinterface

interface pts_rsp_if import pts_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic [THREAD_W-1:0]  running_thread;
   logic                 none_ready;
   logic signed [COUNT_W-1:0] sem_count;

   modport source (output valid, running_thread, none_ready, sem_count,
                   input ready);
   modport sink   (input valid, running_thread, none_ready, sem_count,
                   output ready);
endinterface

// ===== rtl/core/pts_ram.sv =====
module pts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/priority_thread_scheduler.sv =====
// Channel   Ports        Dir  Transfer moves
// request   req_ch.*     in   operation, sem_index, sleep_ticks, init_count
// response  rsp_ch.*     out  running_thread, none_ready, sem_count
// config    csr_wr_*     in   thread_priorities, written on csr_wr_en
//
// Init, non-blocking wait, signal leaving a positive count: IDLE, SEM, DONE, then the output register.
// Tick, reschedule, sleep, blocking wait, other signal: IDLE, SEM, SCAN, DONE, then the output register;
// SCAN walks over the thread memory, one entry read per cycle.
// Reset is synchronous; per-entry valid bits make both memories read as zero.
// A new request is taken once the previous result sits in the output register.
module priority_thread_scheduler import pts_pkg::*; #(
   parameter int THREADS    = PTS_THREADS,
   parameter int SEMAPHORES = PTS_SEMAPHORES
) (
   input  logic               clock,
   input  logic               reset,
   pts_req_if.sink            req_ch,
   pts_rsp_if.source          rsp_ch,
   input  logic               csr_wr_en,
   input  logic [PRIOS_W-1:0] csr_wr_data
);

   localparam int TH_AW  = $clog2(THREADS);
   localparam int SEM_AW = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;
   localparam int TH_DW  = BLK_W + TICKS_W;
   localparam int CNT_W  = $clog2(THREADS + 1);

   function automatic logic [THREAD_W-1:0] ring_next(input logic [THREAD_W-1:0] t);
      return (t == THREAD_W'(THREADS - 1)) ? '0 : t + THREAD_W'(1);
   endfunction

   // control state
   state_type            state_ff, state_in;
   mode_type             mode_ff, mode_in;
   logic [THREAD_W-1:0]  cur_ff, cur_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic                 found_ff, found_in;
   logic                 resched_ff, resched_in;
   logic [THREADS-1:0]   thr_valid_ff;
   logic [SEMAPHORES-1:0] sem_valid_ff;
   logic                 thr_rv_ff, thr_rv_in;
   logic                 sem_rv_ff, sem_rv_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PRIOS_W-1:0]   prio_ff;

   // payload
   logic [OP_W-1:0]      op_ff, op_in;
   logic [SEM_IDX_W-1:0] si_ff, si_in;
   logic [TICKS_W-1:0]   ticks_ff, ticks_in;
   logic [COUNT_W-1:0]   initv_ff, initv_in;
   logic [THREAD_W-1:0]  ptr_ff, ptr_in;
   logic [THREAD_W-1:0]  ptrq_ff, ptrq_in;
   logic [PRIO_W-1:0]    best_ff, best_in;
   logic [THREAD_W-1:0]  pick_ff, pick_in;
   logic [COUNT_W-1:0]   sem_out_ff, sem_out_in;
   logic [THREAD_W-1:0]  rsp_thread_ff, rsp_thread_in;
   logic                 rsp_none_ff, rsp_none_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   // memory ports
   logic                 thr_we;
   logic [TH_AW-1:0]     thr_waddr, thr_raddr;
   logic [TH_DW-1:0]     thr_wdata, thr_rdata;
   logic                 sem_we;
   logic [SEM_AW-1:0]    sem_waddr, sem_raddr;
   logic [COUNT_W-1:0]   sem_wdata, sem_rdata;

   // decoded read data
   logic [TICKS_W-1:0]   thr_sleep;
   logic [BLK_W-1:0]     thr_blk;
   logic [COUNT_W-1:0]   sem_val;
   logic                 sem_ok;
   logic [BLK_W-1:0]     blk_mark;
   logic [COUNT_W-1:0]   sem_new;
   logic [PRIO_W-1:0]    prio_q;
   logic [THREAD_W-1:0]  next_thread;

   pts_ram #(.WIDTH(TH_DW), .DEPTH(THREADS)) u_thr_ram (
      .clock (clock),
      .we    (thr_we),
      .waddr (thr_waddr),
      .wdata (thr_wdata),
      .raddr (thr_raddr),
      .rdata (thr_rdata)
   );

   pts_ram #(.WIDTH(COUNT_W), .DEPTH(SEMAPHORES)) u_sem_ram (
      .clock (clock),
      .we    (sem_we),
      .waddr (sem_waddr),
      .wdata (sem_wdata),
      .raddr (sem_raddr),
      .rdata (sem_rdata)
   );

   // mask entries never written to zero
   assign thr_sleep = thr_rv_ff ? thr_rdata[TICKS_W-1:0] : '0;
   assign thr_blk   = thr_rv_ff ? thr_rdata[TH_DW-1:TICKS_W] : '0;
   assign sem_val   = sem_rv_ff ? sem_rdata : '0;
   assign sem_ok    = {1'b0, si_ff} < 3'(SEMAPHORES);
   assign blk_mark  = BLK_W'(si_ff) + BLK_W'(1);
   assign prio_q    = PRIO_W'(prio_ff >> {ptrq_ff, 3'b000});
   assign next_thread = (resched_ff && found_ff) ? pick_ff : cur_ff;

   assign req_ch.ready = (state_ff == ST_IDLE);

   // sequencer: next state, memory accesses and result
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      cur_in        = cur_ff;
      n_in          = n_ff;
      found_in      = found_ff;
      resched_in    = resched_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      op_in         = op_ff;
      si_in         = si_ff;
      ticks_in      = ticks_ff;
      initv_in      = initv_ff;
      ptr_in        = ptr_ff;
      ptrq_in       = ptrq_ff;
      best_in       = best_ff;
      pick_in       = pick_ff;
      sem_out_in    = sem_out_ff;
      rsp_thread_in = rsp_thread_ff;
      rsp_none_in   = rsp_none_ff;
      rsp_count_in  = rsp_count_ff;
      thr_we        = 1'b0;
      thr_waddr     = TH_AW'(cur_ff);
      thr_wdata     = {thr_blk, thr_sleep};
      thr_raddr     = TH_AW'(cur_ff);
      sem_we        = 1'b0;
      sem_waddr     = SEM_AW'(si_ff);
      sem_wdata     = sem_val;
      sem_raddr     = SEM_AW'(si_ff);
      sem_new       = sem_val;

      unique case (state_ff)
         ST_IDLE: begin
            // take the request, read its semaphore and the current thread
            sem_raddr = SEM_AW'(req_ch.sem_index);
            if (req_ch.valid) begin
               op_in    = req_ch.operation;
               si_in    = req_ch.sem_index;
               ticks_in = req_ch.sleep_ticks;
               initv_in = req_ch.init_count;
               state_in = ST_SEM;
            end
         end

         ST_SEM: begin
            resched_in = 1'b0;
            found_in   = 1'b0;
            best_in    = PRIO_NONE;
            pick_in    = cur_ff;
            n_in       = '0;
            state_in   = ST_DONE;
            case (op_ff)
               OP_TICK: begin
                  mode_in  = MODE_TICK;
                  ptr_in   = '0;
                  state_in = ST_SCAN;
               end
               OP_RESCHED: begin
                  mode_in    = MODE_RESCHED;
                  ptr_in     = ring_next(cur_ff);
                  resched_in = 1'b1;
                  state_in   = ST_SCAN;
               end
               OP_SLEEP: begin
                  thr_we     = 1'b1;
                  thr_wdata  = {thr_blk, ticks_ff};
                  mode_in    = MODE_RESCHED;
                  ptr_in     = ring_next(cur_ff);
                  resched_in = 1'b1;
                  state_in   = ST_SCAN;
               end
               OP_WAIT: begin
                  if (sem_ok) begin
                     sem_new   = sem_val - COUNT_W'(1);
                     sem_we    = 1'b1;
                     sem_wdata = sem_new;
                     if (sem_new[COUNT_W-1]) begin
                        thr_we     = 1'b1;
                        thr_wdata  = {blk_mark, thr_sleep};
                        mode_in    = MODE_RESCHED;
                        ptr_in     = ring_next(cur_ff);
                        resched_in = 1'b1;
                        state_in   = ST_SCAN;
                     end
                  end
               end
               OP_SIGNAL: begin
                  if (sem_ok) begin
                     sem_new   = sem_val + COUNT_W'(1);
                     sem_we    = 1'b1;
                     sem_wdata = sem_new;
                     if (sem_new[COUNT_W-1] || sem_new == '0) begin
                        mode_in  = MODE_SIGNAL;
                        ptr_in   = ring_next(cur_ff);
                        state_in = ST_SCAN;
                     end
                  end
               end
               OP_INIT: begin
                  if (sem_ok) begin
                     sem_new   = initv_ff;
                     sem_we    = 1'b1;
                     sem_wdata = sem_new;
                  end
               end
               default: begin
               end
            endcase
            sem_out_in = sem_ok ? sem_new : '0;
         end

         ST_SCAN: begin
            // issue the next thread read
            if (n_ff < CNT_W'(THREADS)) begin
               thr_raddr = TH_AW'(ptr_ff);
               ptr_in    = ring_next(ptr_ff);
               ptrq_in   = ptr_ff;
            end else begin
               state_in = ST_DONE;
            end
            n_in = n_ff + CNT_W'(1);
            // process the entry read in the previous cycle
            if (n_ff != '0) begin
               thr_waddr = TH_AW'(ptrq_ff);
               unique case (mode_ff)
                  MODE_TICK: begin
                     if (thr_sleep != '0) begin
                        thr_we    = 1'b1;
                        thr_wdata = {thr_blk, thr_sleep - TICKS_W'(1)};
                     end
                  end
                  MODE_RESCHED: begin
                     if (prio_q < best_ff && thr_blk == '0 && thr_sleep == '0) begin
                        best_in  = prio_q;
                        pick_in  = ptrq_ff;
                        found_in = 1'b1;
                     end
                  end
                  MODE_SIGNAL: begin
                     if (!found_ff && thr_blk == blk_mark) begin
                        thr_we    = 1'b1;
                        thr_wdata = {BLK_W'(0), thr_sleep};
                        found_in  = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_DONE: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_thread_in = next_thread;
               rsp_none_in   = resched_ff && !found_ff;
               rsp_count_in  = sem_out_ff;
               cur_in        = next_thread;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // valid bits of the entries being read
      thr_rv_in = thr_valid_ff[thr_raddr];
      sem_rv_in = (32'(sem_raddr) < SEMAPHORES) && sem_valid_ff[sem_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_TICK;
         cur_ff       <= '0;
         n_ff         <= '0;
         found_ff     <= 1'b0;
         resched_ff   <= 1'b0;
         thr_valid_ff <= '0;
         sem_valid_ff <= '0;
         thr_rv_ff    <= 1'b0;
         sem_rv_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prio_ff      <= PRIO_RESET;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         cur_ff       <= cur_in;
         n_ff         <= n_in;
         found_ff     <= found_in;
         resched_ff   <= resched_in;
         thr_rv_ff    <= thr_rv_in;
         sem_rv_ff    <= sem_rv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (thr_we) begin
            thr_valid_ff[thr_waddr] <= 1'b1;
         end
         if (sem_we) begin
            sem_valid_ff[sem_waddr] <= 1'b1;
         end
         if (csr_wr_en) begin
            prio_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      si_ff         <= si_in;
      ticks_ff      <= ticks_in;
      initv_ff      <= initv_in;
      ptr_ff        <= ptr_in;
      ptrq_ff       <= ptrq_in;
      best_ff       <= best_in;
      pick_ff       <= pick_in;
      sem_out_ff    <= sem_out_in;
      rsp_thread_ff <= rsp_thread_in;
      rsp_none_ff   <= rsp_none_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.running_thread = rsp_thread_ff;
   assign rsp_ch.none_ready     = rsp_none_ff;
   assign rsp_ch.sem_count      = rsp_count_ff;

`ifndef ASSERT_OFF
   // a scan never writes the entry it is reading in the same cycle
   a_scan_no_collide: assert property (@(posedge clock) disable iff (reset)
      (thr_we && state_ff == ST_SCAN && n_ff < CNT_W'(THREADS))
         |-> (thr_waddr != thr_raddr))
      else $error("thread memory write collides with scan read");

   // the running thread stays inside the ring
   a_cur_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, cur_ff} < 4'(THREADS)))
      else $error("current thread out of range");

   // a new result appears only from the completion step
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised outside completion");

   // an accepted request goes to the semaphore step next
   a_accept_flow: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == ST_SEM))
      else $error("accepted request did not advance");
`endif

endmodule
